FILE: rtl/core/gve_pkg.sv
// ----------------------------------------------------------------------------
// GPS velocity and heading estimator package
// Widths, sequencer states, control structs and the arctangent table.
// ----------------------------------------------------------------------------
package gve_pkg;

  localparam int RID_W     = 8;
  localparam int POS_W     = 40;
  localparam int DIF_W     = POS_W + 1;
  localparam int TIME_W    = 63;
  localparam int SPD_W     = 24;
  localparam int HDG_W     = 16;
  localparam int LIM_W     = 23;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 1;

  localparam int SUM_W     = 82;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int NUM_W     = 57;
  localparam int CW        = 45;
  localparam int ACC_W     = 32;
  localparam int CNT_W     = 6;

  localparam int SQ_STEPS     = POS_W;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int DIV_STEPS    = NUM_W;
  localparam int CORDIC_STEPS = 30;
  localparam int NORM_BIT     = 40;

  localparam logic [TIME_W-1:0] MIN_GAP = TIME_W'(10);
  localparam logic [15:0] SPEED_SCALE = 16'd62500;
  localparam logic signed [CW-1:0] NORM_HI = CW'(1) <<< NORM_BIT;
  localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_QUARTER  = 32'h4000_0000;
  localparam logic [ACC_W-1:0] ACC_NQUARTER = 32'hC000_0000;
  localparam logic [ACC_W-1:0] ACC_HALF_LSB = 32'h0000_8000;

  localparam logic [CFG_IDX_W-1:0] CFG_SEL_RX      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_MUL, ST_DIV, ST_ROT, ST_NORM, ST_CORD, ST_DONE
  } state_t;

  typedef struct packed {
    state_t            state;
    logic [CNT_W-1:0]  cnt;
  } seq_ctrl_t;

  typedef struct packed {
    logic norm_done;
  } dp_stat_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [ACC_W-1:0] arc_at(input logic [4:0] i);
    logic [ACC_W-1:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/gve_in_if.sv
// ----------------------------------------------------------------------------
// GPS fix channel
// Valid/ready channel carrying one position fix per item.
// ----------------------------------------------------------------------------
interface gve_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [gve_pkg::RID_W-1:0]            receiver_id;
  logic signed [gve_pkg::POS_W-1:0]     pos_x;
  logic signed [gve_pkg::POS_W-1:0]     pos_y;
  logic [gve_pkg::TIME_W-1:0]           fix_time;

  modport source(output valid, receiver_id, pos_x, pos_y, fix_time, input ready);
  modport sink(input valid, receiver_id, pos_x, pos_y, fix_time, output ready);
endinterface

FILE: rtl/core/gve_out_if.sv
// ----------------------------------------------------------------------------
// Velocity result channel
// Valid/ready channel carrying position, heading, speed and time per item.
// ----------------------------------------------------------------------------
interface gve_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gve_pkg::POS_W-1:0]     out_x;
  logic signed [gve_pkg::POS_W-1:0]     out_y;
  logic signed [gve_pkg::HDG_W-1:0]     heading;
  logic signed [gve_pkg::SPD_W-1:0]     speed;
  logic [gve_pkg::TIME_W-1:0]           out_time;

  modport source(output valid, out_x, out_y, heading, speed, out_time, input ready);
  modport sink(input valid, out_x, out_y, heading, speed, out_time, output ready);
endinterface

FILE: rtl/core/gps_velocity_heading_estimator_unit.sv
// ----------------------------------------------------------------------------
// GPS velocity and heading estimator
// Turns successive position fixes into speed and heading results.
// ----------------------------------------------------------------------------
// Usage: fixes enter on in_ch, one item per valid/ready handshake. Fixes from
// receivers other than the selected one are absorbed and give no result. The
// first fix from the selected receiver seeds the stored position and time and
// also gives no result. Every later fix gives one item on out_ch. A computed
// fix runs shift-add steps for the squared distance, the root digits, a
// multiply, the divide steps, a quadrant turn, the normalize shifts and the
// CORDIC steps, all on one shared datapath. A fix whose time gap is under
// 10 us skips the arithmetic and goes straight to its result. in_ch is not
// ready while a fix is in work. The result sits in an output register, so a
// stalled receiver holds the block only when the next result is finished and
// the register is full. The configuration port writes the selected receiver
// and the speed limit; write it only while the block is idle. Synchronous
// reset clears the sequencer, the seeded flag, the stored fix and the output
// valid, selects receiver 1 and sets the speed limit to zero.
// ----------------------------------------------------------------------------
module gps_velocity_heading_estimator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  gve_in_if.sink                            in_ch,
  gve_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [gve_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gve_pkg::CFG_W-1:0]         cfg_data
);

  logic [gve_pkg::RID_W-1:0]           sel_rx_r;
  logic [gve_pkg::LIM_W-1:0]           limit_r;
  logic                                seen_r;
  logic signed [gve_pkg::POS_W-1:0]    prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic [gve_pkg::TIME_W-1:0]          prev_t_r, cur_t_r;
  logic signed [gve_pkg::SPD_W-1:0]    prev_spd_r;
  logic signed [gve_pkg::HDG_W-1:0]    prev_hdg_r;
  logic                                dt_pos_r, skip_r;
  logic                                out_valid_r;
  logic signed [gve_pkg::POS_W-1:0]    o_x_r, o_y_r;
  logic signed [gve_pkg::HDG_W-1:0]    o_hdg_r;
  logic signed [gve_pkg::SPD_W-1:0]    o_spd_r;
  logic [gve_pkg::TIME_W-1:0]          o_t_r;

  gve_pkg::seq_ctrl_t                  ctrl;
  gve_pkg::dp_stat_t                   stat;

  logic                                in_acc, mine, start, small_gap, out_free, commit;
  logic                                fix_ok, dt_neg;
  logic signed [gve_pkg::DIF_W-1:0]    dx, dy;
  logic [gve_pkg::TIME_W:0]            dt;
  logic [gve_pkg::TIME_W-1:0]          adt;
  logic [gve_pkg::NUM_W-1:0]           quot;
  logic signed [gve_pkg::HDG_W-1:0]    hdg;
  logic signed [gve_pkg::SPD_W-1:0]    spd_new;
  logic signed [gve_pkg::POS_W-1:0]    nx, ny;
  logic signed [gve_pkg::SPD_W-1:0]    nspd;
  logic signed [gve_pkg::HDG_W-1:0]    nhdg;

  assign in_ch.ready = (ctrl.state == gve_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign mine        = (in_ch.receiver_id == sel_rx_r);
  assign start       = in_acc && mine && seen_r;

  // Displacement and signed time gap against the stored fix, the last one kept.
  assign dx        = gve_pkg::DIF_W'(in_ch.pos_x) - gve_pkg::DIF_W'(prev_x_r);
  assign dy        = gve_pkg::DIF_W'(in_ch.pos_y) - gve_pkg::DIF_W'(prev_y_r);
  assign dt        = {1'b0, in_ch.fix_time} - {1'b0, prev_t_r};
  assign dt_neg    = dt[gve_pkg::TIME_W];
  assign adt       = dt_neg ? gve_pkg::TIME_W'(-dt) : gve_pkg::TIME_W'(dt);
  assign small_gap = (adt < gve_pkg::MIN_GAP);

  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = (ctrl.state == gve_pkg::ST_DONE) && out_free;

  gve_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .skip     (small_gap),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  gve_dp u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .load    (start),
    .dx_in   (dx),
    .dy_in   (dy),
    .adt_in  (adt),
    .quot    (quot),
    .heading (hdg),
    .stat    (stat)
  );

  // A fix is rejected for a too small gap, or for a forward speed over the
  // limit; backward time never trips the limit and saturates when too large.
  assign fix_ok = !skip_r &&
                  !(dt_pos_r && (quot > gve_pkg::NUM_W'(limit_r)));

  always_comb begin
    if (dt_pos_r) begin
      spd_new = gve_pkg::SPD_W'(quot);
    end else if (quot >= gve_pkg::NUM_W'({1'b1, {(gve_pkg::SPD_W-1){1'b0}}})) begin
      spd_new = gve_pkg::SPD_MIN;
    end else begin
      spd_new = -gve_pkg::SPD_W'(quot);
    end
    nx   = fix_ok ? cur_x_r : prev_x_r;
    ny   = fix_ok ? cur_y_r : prev_y_r;
    nspd = fix_ok ? spd_new : prev_spd_r;
    nhdg = fix_ok ? hdg     : prev_hdg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_rx_r    <= gve_pkg::RID_W'(1);
      limit_r     <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_t_r    <= '0;
      prev_spd_r  <= '0;
      prev_hdg_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gve_pkg::CFG_SEL_RX:      sel_rx_r <= cfg_data[gve_pkg::RID_W-1:0];
          gve_pkg::CFG_SPEED_LIMIT: limit_r  <= cfg_data[gve_pkg::LIM_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc && mine && !seen_r) begin
        seen_r     <= 1'b1;
        prev_x_r   <= in_ch.pos_x;
        prev_y_r   <= in_ch.pos_y;
        prev_t_r   <= in_ch.fix_time;
        prev_spd_r <= '0;
        prev_hdg_r <= '0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (fix_ok) begin
          prev_x_r   <= cur_x_r;
          prev_y_r   <= cur_y_r;
          prev_t_r   <= cur_t_r;
          prev_spd_r <= spd_new;
          prev_hdg_r <= hdg;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: current fix and the result register.
  always_ff @(posedge clk) begin
    if (start) begin
      cur_x_r  <= in_ch.pos_x;
      cur_y_r  <= in_ch.pos_y;
      cur_t_r  <= in_ch.fix_time;
      dt_pos_r <= !dt_neg;
      skip_r   <= small_gap;
    end
    if (commit) begin
      o_x_r   <= nx;
      o_y_r   <= ny;
      o_hdg_r <= nhdg;
      o_spd_r <= nspd;
      o_t_r   <= cur_t_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_x    = o_x_r;
  assign out_ch.out_y    = o_y_r;
  assign out_ch.heading  = o_hdg_r;
  assign out_ch.speed    = o_spd_r;
  assign out_ch.out_time = o_t_r;

`ifndef SYNTHESIS
  a_new_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.state == gve_pkg::ST_DONE))
    else $error("result appeared without a finished fix");

  a_small_gap_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (start && small_gap) |=> (ctrl.state == gve_pkg::ST_DONE))
    else $error("small time gap did not skip the arithmetic");

  a_foreign_fix_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !mine) |=> (ctrl.state == gve_pkg::ST_IDLE) && $stable(prev_t_r))
    else $error("fix from another receiver changed state");

  a_squares_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.state == gve_pkg::ST_SQ) &&
    (ctrl.cnt == gve_pkg::CNT_W'(gve_pkg::SQ_STEPS - 1))
    |=> (ctrl.state == gve_pkg::ST_SQRT))
    else $error("square phase did not hand over to root phase");
`endif

endmodule

FILE: rtl/core/gve_seq.sv
// ----------------------------------------------------------------------------
// GVE sequencer
// Steps the shared datapath: square, root, mul, div, turn, norm, CORDIC.
// ----------------------------------------------------------------------------
module gve_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 skip,
  input  logic                 out_free,
  input  gve_pkg::dp_stat_t    stat,
  output gve_pkg::seq_ctrl_t   ctrl
);

  gve_pkg::state_t               state_r, state_nxt;
  logic [gve_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gve_pkg::ST_IDLE: begin
        if (start) state_nxt = skip ? gve_pkg::ST_DONE : gve_pkg::ST_SQ;
      end
      gve_pkg::ST_SQ: begin
        if (cnt_r == gve_pkg::CNT_W'(gve_pkg::SQ_STEPS - 1)) state_nxt = gve_pkg::ST_SQRT;
      end
      gve_pkg::ST_SQRT: begin
        if (cnt_r == gve_pkg::CNT_W'(gve_pkg::SQRT_STEPS - 1)) state_nxt = gve_pkg::ST_MUL;
      end
      gve_pkg::ST_MUL:  state_nxt = gve_pkg::ST_DIV;
      gve_pkg::ST_DIV: begin
        if (cnt_r == gve_pkg::CNT_W'(gve_pkg::DIV_STEPS - 1)) state_nxt = gve_pkg::ST_ROT;
      end
      gve_pkg::ST_ROT:  state_nxt = gve_pkg::ST_NORM;
      gve_pkg::ST_NORM: begin
        if (stat.norm_done) state_nxt = gve_pkg::ST_CORD;
      end
      gve_pkg::ST_CORD: begin
        if (cnt_r == gve_pkg::CNT_W'(gve_pkg::CORDIC_STEPS - 1)) state_nxt = gve_pkg::ST_DONE;
      end
      gve_pkg::ST_DONE: begin
        if (out_free) state_nxt = gve_pkg::ST_IDLE;
      end
      default: state_nxt = gve_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
  end

  always_comb begin
    ctrl.state = state_r;
    ctrl.cnt   = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gve_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/gve_dp.sv
// ----------------------------------------------------------------------------
// GVE datapath
// Shift-add squares, digit-by-digit root, restoring divide and CORDIC atan2.
// ----------------------------------------------------------------------------
module gve_dp (
  input  logic                                clk,
  input  gve_pkg::seq_ctrl_t                  ctrl,
  input  logic                                load,
  input  logic signed [gve_pkg::DIF_W-1:0]    dx_in,
  input  logic signed [gve_pkg::DIF_W-1:0]    dy_in,
  input  logic [gve_pkg::TIME_W-1:0]          adt_in,
  output logic [gve_pkg::NUM_W-1:0]           quot,
  output logic signed [gve_pkg::HDG_W-1:0]    heading,
  output gve_pkg::dp_stat_t                   stat
);

  logic signed [gve_pkg::DIF_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [gve_pkg::TIME_W-1:0]        adt_r, adt_nxt;
  logic [gve_pkg::POS_W-1:0]         ax_r, ax_nxt, ay_r, ay_nxt;
  logic [gve_pkg::SUM_W-1:0]         mx_r, mx_nxt, my_r, my_nxt, sum_r, sum_nxt;
  logic [gve_pkg::ROOT_W-1:0]        root_r, root_nxt;
  logic [gve_pkg::REM_W-1:0]         rem_r, rem_nxt, rem_sh, trial;
  logic [gve_pkg::NUM_W-1:0]         num_r, num_nxt, q_r, q_nxt;
  logic [gve_pkg::TIME_W-1:0]        drem_r, drem_nxt;
  logic [gve_pkg::TIME_W:0]          dsh;
  logic signed [gve_pkg::CW-1:0]     cx_r, cx_nxt, cy_r, cy_nxt, xs, ys;
  logic [gve_pkg::ACC_W-1:0]         acc_r, acc_nxt, acc_rnd;
  logic                              zero_r, zero_nxt;
  logic                              norm_done;

  assign norm_done = zero_r || (cx_r >= gve_pkg::NORM_HI) || (cy_r >= gve_pkg::NORM_HI) ||
                     (cy_r <= -gve_pkg::NORM_HI);
  assign rem_sh  = {rem_r[gve_pkg::REM_W-3:0], sum_r[gve_pkg::SUM_W-1 -: 2]};
  assign trial   = gve_pkg::REM_W'({root_r, 2'b01});
  assign dsh     = {drem_r, num_r[gve_pkg::NUM_W-1]};
  assign xs      = cx_r >>> ctrl.cnt[4:0];
  assign ys      = cy_r >>> ctrl.cnt[4:0];
  assign acc_rnd = acc_r + gve_pkg::ACC_HALF_LSB;

  always_comb begin
    dx_nxt = dx_r;   dy_nxt = dy_r;   adt_nxt = adt_r;
    ax_nxt = ax_r;   ay_nxt = ay_r;   mx_nxt = mx_r;  my_nxt = my_r;
    sum_nxt = sum_r; root_nxt = root_r; rem_nxt = rem_r;
    num_nxt = num_r; q_nxt = q_r;     drem_nxt = drem_r;
    cx_nxt = cx_r;   cy_nxt = cy_r;   acc_nxt = acc_r; zero_nxt = zero_r;
    if (load) begin
      dx_nxt   = dx_in;
      dy_nxt   = dy_in;
      adt_nxt  = adt_in;
      ax_nxt   = dx_in[gve_pkg::DIF_W-1] ? gve_pkg::POS_W'(-dx_in) : gve_pkg::POS_W'(dx_in);
      ay_nxt   = dy_in[gve_pkg::DIF_W-1] ? gve_pkg::POS_W'(-dy_in) : gve_pkg::POS_W'(dy_in);
      mx_nxt   = gve_pkg::SUM_W'(ax_nxt);
      my_nxt   = gve_pkg::SUM_W'(ay_nxt);
      sum_nxt  = '0;
      root_nxt = '0;
      rem_nxt  = '0;
      q_nxt    = '0;
      drem_nxt = '0;
    end else begin
      case (ctrl.state)
        gve_pkg::ST_SQ: begin
          sum_nxt = sum_r + (ax_r[0] ? mx_r : '0) + (ay_r[0] ? my_r : '0);
          ax_nxt  = ax_r >> 1;
          ay_nxt  = ay_r >> 1;
          mx_nxt  = mx_r << 1;
          my_nxt  = my_r << 1;
        end
        gve_pkg::ST_SQRT: begin
          sum_nxt = sum_r << 2;
          if (rem_sh >= trial) begin
            rem_nxt  = rem_sh - trial;
            root_nxt = {root_r[gve_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rem_nxt  = rem_sh;
            root_nxt = {root_r[gve_pkg::ROOT_W-2:0], 1'b0};
          end
        end
        gve_pkg::ST_MUL: begin
          num_nxt = gve_pkg::NUM_W'(root_r) * gve_pkg::NUM_W'(gve_pkg::SPEED_SCALE);
        end
        gve_pkg::ST_DIV: begin
          num_nxt = num_r << 1;
          if (dsh >= {1'b0, adt_r}) begin
            drem_nxt = gve_pkg::TIME_W'(dsh - {1'b0, adt_r});
            q_nxt    = {q_r[gve_pkg::NUM_W-2:0], 1'b1};
          end else begin
            drem_nxt = gve_pkg::TIME_W'(dsh);
            q_nxt    = {q_r[gve_pkg::NUM_W-2:0], 1'b0};
          end
        end
        gve_pkg::ST_ROT: begin
          zero_nxt = (dx_r == '0) && (dy_r == '0);
          if (dx_r < 0) begin
            if (dy_r >= 0) begin
              cx_nxt  = gve_pkg::CW'(dy_r);
              cy_nxt  = -gve_pkg::CW'(dx_r);
              acc_nxt = gve_pkg::ACC_QUARTER;
            end else begin
              cx_nxt  = -gve_pkg::CW'(dy_r);
              cy_nxt  = gve_pkg::CW'(dx_r);
              acc_nxt = gve_pkg::ACC_NQUARTER;
            end
          end else begin
            cx_nxt  = gve_pkg::CW'(dx_r);
            cy_nxt  = gve_pkg::CW'(dy_r);
            acc_nxt = '0;
          end
        end
        gve_pkg::ST_NORM: begin
          if (!norm_done) begin
            cx_nxt = cx_r <<< 1;
            cy_nxt = cy_r <<< 1;
          end
        end
        gve_pkg::ST_CORD: begin
          if (cy_r > 0) begin
            cx_nxt  = cx_r + ys;
            cy_nxt  = cy_r - xs;
            acc_nxt = acc_r + gve_pkg::arc_at(ctrl.cnt[4:0]);
          end else begin
            cx_nxt  = cx_r - ys;
            cy_nxt  = cy_r + xs;
            acc_nxt = acc_r - gve_pkg::arc_at(ctrl.cnt[4:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;   dy_r <= dy_nxt;   adt_r <= adt_nxt;
    ax_r <= ax_nxt;   ay_r <= ay_nxt;   mx_r <= mx_nxt;  my_r <= my_nxt;
    sum_r <= sum_nxt; root_r <= root_nxt; rem_r <= rem_nxt;
    num_r <= num_nxt; q_r <= q_nxt;     drem_r <= drem_nxt;
    cx_r <= cx_nxt;   cy_r <= cy_nxt;   acc_r <= acc_nxt; zero_r <= zero_nxt;
  end

  assign quot           = q_r;
  assign heading        = zero_r ? '0 : acc_rnd[gve_pkg::ACC_W-1 -: gve_pkg::HDG_W];
  assign stat.norm_done = norm_done;

endmodule

FILE: sim/gve_velocity_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Velocity result checker
// Watches the fix, result and configuration ports, predicts each result
// from its own copy of the estimator state and compares field by field.
// ----------------------------------------------------------------------------
module gve_velocity_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  gve_in_if                              fix_ch,
  gve_out_if                             vel_ch,
  input  logic                           cfg_we,
  input  logic [gve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gve_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           run_done,
  output int                             fail_count,
  output int                             pending,
  output int                             results_seen,
  output int                             fixes_used
);

  typedef struct packed {
    logic [gve_pkg::POS_W-1:0]  x;
    logic [gve_pkg::POS_W-1:0]  y;
    logic [gve_pkg::HDG_W-1:0]  hdg;
    logic [gve_pkg::SPD_W-1:0]  spd;
    logic [gve_pkg::TIME_W-1:0] t;
  } velocity_t;

  // atan(2^-i), pi/2^31 per unit
  localparam logic [31:0] ARC_TAB [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  velocity_t       velocity_q[$];
  int              mismatches;
  logic [7:0]      sel_rx;
  logic [22:0]     spd_limit;
  bit              seeded;
  longint          last_x, last_y, last_t;
  logic [gve_pkg::SPD_W-1:0] last_spd;
  logic [gve_pkg::HDG_W-1:0] last_hdg;

  function automatic logic [41:0] floor_root(input logic [83:0] v);
    logic [41:0] r;
    logic [41:0] c;
    r = '0;
    for (int b = 41; b >= 0; b--) begin
      c = r | (42'd1 << b);
      if ({42'd0, c} * {42'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [gve_pkg::HDG_W-1:0] bearing(input longint x0, input longint y0);
    longint x, y, tmp, xs, ys;
    logic [31:0] acc;
    logic [31:0] rounded;
    x = x0;
    y = y0;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      tmp = x;
      if (y >= 0) begin
        x = y; y = -tmp; acc = 32'h4000_0000;
      end else begin
        x = -y; y = tmp; acc = 32'hC000_0000;
      end
    end
    while (x < (64'sd1 <<< 40) && y < (64'sd1 <<< 40) && y > -(64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; acc = acc + ARC_TAB[i];
      end else begin
        x = x - ys; y = y + xs; acc = acc - ARC_TAB[i];
      end
    end
    rounded = (acc + 32'h8000) >> 16;
    return rounded[15:0];
  endfunction

  // Advances the estimator state for one fix; returns 1 when it gives a result.
  function automatic bit track_fix(input logic [7:0] rid,
                                   input logic [gve_pkg::POS_W-1:0] px,
                                   input logic [gve_pkg::POS_W-1:0] py,
                                   input logic [gve_pkg::TIME_W-1:0] pt,
                                   output velocity_t v);
    longint x, y, t, dx, dy, dt, adt, ax, ay;
    logic [83:0] dist_sq;
    logic [63:0] d, q;
    x = longint'($signed(px));
    y = longint'($signed(py));
    t = longint'({1'b0, pt});
    v = '0;
    if (rid != sel_rx) return 0;
    if (!seeded) begin
      seeded = 1;
      last_x = x; last_y = y; last_t = t;
      last_spd = '0; last_hdg = '0;
      return 0;
    end
    dx = x - last_x;
    dy = y - last_y;
    dt = t - last_t;
    adt = (dt < 0) ? -dt : dt;
    if (adt >= 10) begin
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      dist_sq = 84'(ax) * 84'(ax) + 84'(ay) * 84'(ay);
      d = 64'(floor_root(dist_sq));
      q = (d * 64'd62500) / 64'(adt);
      // A forward fix faster than the limit is thrown away.
      if (!(dt > 0 && q > 64'(spd_limit))) begin
        if (dt > 0) last_spd = q[gve_pkg::SPD_W-1:0];
        else last_spd = (q > 64'h80_0000) ? 24'h80_0000 : -q[gve_pkg::SPD_W-1:0];
        last_hdg = bearing(dx, dy);
        last_x = x; last_y = y; last_t = t;
      end
    end
    v.x = last_x[gve_pkg::POS_W-1:0];
    v.y = last_y[gve_pkg::POS_W-1:0];
    v.hdg = last_hdg;
    v.spd = last_spd;
    v.t = pt;
    return 1;
  endfunction

  always @(posedge clk) begin
    velocity_t v, want;
    if (!rst_n) begin
      sel_rx = 8'd1;
      spd_limit = '0;
      seeded = 0;
      last_x = 0; last_y = 0; last_t = 0;
      last_spd = '0; last_hdg = '0;
      velocity_q.delete();
      mismatches = 0;
      results_seen = 0;
      fixes_used = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gve_pkg::CFG_SEL_RX) sel_rx = cfg_data[7:0];
        else if (cfg_index == gve_pkg::CFG_SPEED_LIMIT) spd_limit = cfg_data[22:0];
      end
      if (fix_ch.valid && fix_ch.ready) begin
        if (fix_ch.receiver_id == sel_rx) fixes_used++;
        if (track_fix(fix_ch.receiver_id, fix_ch.pos_x, fix_ch.pos_y, fix_ch.fix_time, v))
          velocity_q.push_back(v);
      end
      if (vel_ch.valid && vel_ch.ready) begin
        results_seen++;
        v = {vel_ch.out_x, vel_ch.out_y, vel_ch.heading, vel_ch.speed, vel_ch.out_time};
        if (velocity_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no fix pending: %h", $realtime, v);
        end else begin
          want = velocity_q.pop_front();
          if (v !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch x %h/%h y %h/%h hdg %h/%h spd %h/%h t %h/%h (exp/got)",
                       $realtime, want.x, v.x, want.y, v.y, want.hdg, v.hdg,
                       want.spd, v.spd, want.t, v.t);
          end
        end
      end
    end
    pending = velocity_q.size();
    fail_count = mismatches + (run_done ? pending : 0);
  end

endmodule

FILE: sim/gps_velocity_heading_estimator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPS velocity and heading estimator testbench
// Feeds directed and random position fixes under bursty input and a stalling
// receiver, steps the configuration through several settings, and leaves
// all checking to the velocity checker beside the block.
// ----------------------------------------------------------------------------
module gps_velocity_heading_estimator_unit_tb;

  localparam longint CYCLE_LIMIT = 4_000_000;
  // Settle a little longer than the longest computed fix takes.
  localparam int SETTLE_CYCLES = 260;
  localparam logic [gve_pkg::POS_W-1:0] POS_MAX = {1'b0, {(gve_pkg::POS_W-1){1'b1}}};
  localparam logic [gve_pkg::POS_W-1:0] POS_MIN = {1'b1, {(gve_pkg::POS_W-1){1'b0}}};
  localparam logic [gve_pkg::TIME_W-1:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [gve_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gve_pkg::CFG_W-1:0] cfg_data;
  logic run_done;
  int fail_count, pending, results_seen, fixes_used;
  longint cycles = 0;

  gve_in_if  fix_ch();
  gve_out_if vel_ch();

  gps_velocity_heading_estimator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(fix_ch), .out_ch(vel_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gve_velocity_checker checker_i (
    .clk(clk), .rst_n(rst_n), .fix_ch(fix_ch), .vel_ch(vel_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .run_done(run_done), .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .fixes_used(fixes_used)
  );

  always #6 clk = ~clk;

  // The whole run is bounded by a cycle budget well above the slowest pass.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("gps_velocity_heading_estimator_unit_tb failed");
      $finish;
    end
  end

  // Receiver stall pattern. When the low nine bits of the cycle count are zero
  // it picks a new mode: always ready, a coin flip per cycle, or long stretches of back pressure.
  logic [1:0] stall_mode;
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      vel_ch.ready <= 1'b0;
      stall_mode <= 2'd0;
      stall_left <= 0;
    end else begin
      if (cycles[8:0] == 9'd0) stall_mode <= 2'($urandom_range(0, 2));
      case (stall_mode)
        2'd0: begin
          vel_ch.ready <= 1'b1;
        end
        2'd1: begin
          vel_ch.ready <= 1'($urandom);
        end
        default: begin
          if (stall_left == 0) begin
            stall_left <= $urandom_range(1, 60);
            vel_ch.ready <= ~vel_ch.ready;
          end else begin
            stall_left <= stall_left - 1;
          end
        end
      endcase
    end
  end

  // Sender burst bookkeeping: a burst of random length, then a random gap if bursty.
  int burst_left;
  bit bursty;

  task automatic send_fix(input logic [7:0] rid, input logic [gve_pkg::POS_W-1:0] x,
                          input logic [gve_pkg::POS_W-1:0] y,
                          input logic [gve_pkg::TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = bursty ? $urandom_range(0, 30) : 0;
      if (gap > 0) begin
        fix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    fix_ch.valid       <= 1'b1;
    fix_ch.receiver_id <= rid;
    fix_ch.pos_x       <= x;
    fix_ch.pos_y       <= y;
    fix_ch.fix_time    <= t;
    do @(posedge clk); while (!fix_ch.ready);
  endtask

  // Registers change only with the block idle: input quiet, every expected
  // result delivered, and time for a fix that gives no result to finish.
  task automatic write_reg(input logic [gve_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gve_pkg::CFG_W-1:0] val);
    fix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random fixes. Most come from the selected receiver and walk forward in
  // time with moderate steps, so that the speed math and the limit both see
  // plausible traffic; the rest are strangers, tiny gaps, reversed time and
  // fully random positions or times.
  logic signed [gve_pkg::POS_W-1:0] walk_x, walk_y;
  logic [gve_pkg::TIME_W-1:0] walk_t;

  task automatic random_phase(input int count, input logic [7:0] sel);
    int used, r;
    logic [7:0] rid;
    logic signed [gve_pkg::POS_W-1:0] step_x, step_y;
    used = 0;
    while (used < count) begin
      r = $urandom_range(0, 99);
      rid = (r < 8) ? 8'($urandom) : sel;
      r = $urandom_range(0, 99);
      if (r < 5) walk_t = walk_t + 63'($urandom_range(0, 9));
      else if (r < 8) walk_t = walk_t - 63'($urandom_range(0, 9));
      else if (r < 13) walk_t = walk_t - 63'($urandom_range(10, 1_000_000));
      else if (r < 16) walk_t = {31'($urandom), $urandom};
      else walk_t = walk_t + 63'($urandom_range(10, 2_000_000));
      r = $urandom_range(0, 99);
      if (r < 5) begin
        walk_x = {8'($urandom), $urandom};
        walk_y = {8'($urandom), $urandom};
      end else begin
        step_x = 40'($signed(24'($urandom))) >>> $urandom_range(0, 23);
        step_y = 40'($signed(24'($urandom))) >>> $urandom_range(0, 23);
        if (r < 10) step_x = '0;
        walk_x = walk_x + step_x;
        walk_y = walk_y + step_y;
      end
      send_fix(rid, walk_x, walk_y, walk_t);
      if (rid == sel) used++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gve_pkg::CFG_SEL_RX;
    cfg_data = '0;
    run_done = 1'b0;
    fix_ch.valid = 1'b0;
    fix_ch.receiver_id = '0;
    fix_ch.pos_x = '0;
    fix_ch.pos_y = '0;
    fix_ch.fix_time = '0;
    burst_left = 0;
    bursty = 1'b0;
    walk_x = '0;
    walk_y = '0;
    walk_t = 63'd1_000_000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: receiver 1 with the largest speed ceiling, then a zero ceiling.
    write_reg(gve_pkg::CFG_SPEED_LIMIT, 23'h7F_FFFF);
    send_fix(8'd0, 40'd5, 40'd5, 63'd10);        // stranger
    send_fix(8'd255, 40'd5, 40'd5, 63'd10);      // stranger
    send_fix(8'd1, 40'd0, 40'd0, 63'd1000);      // first fix seeds state
    send_fix(8'd1, 40'd0, 40'd0, 63'd2000);      // no movement, heading zero
    send_fix(8'd1, 40'd100, 40'd0, 63'd2005);    // gap too small
    send_fix(8'd1, 40'd4096, 40'd4096, 63'd3000);
    send_fix(8'd1, 40'd0, 40'd8192, 63'd4000);
    send_fix(8'd1, -40'sd4096, 40'd0, 63'd5000);
    send_fix(8'd1, 40'd0, -40'sd4096, 63'd6000);
    send_fix(8'd1, 40'd4096, -40'sd8192, 63'd7000);
    send_fix(8'd1, 40'd0, -40'sd8192, 63'd8000); // due west: heading wraps
    send_fix(8'd1, POS_MAX, POS_MAX, 63'd9000);
    send_fix(8'd1, POS_MIN, POS_MIN, 63'd8990);  // forward and over the limit
    send_fix(8'd1, POS_MIN, POS_MAX, TIME_MAX);
    send_fix(8'd1, 40'd0, 40'd0, 63'd5);
    write_reg(gve_pkg::CFG_SPEED_LIMIT, 23'd0);
    send_fix(8'd1, 40'd4096, 40'd0, 63'd1_000_000); // too fast
    send_fix(8'd1, 40'd4096, 40'd0, 63'd0);          // gap too small
    send_fix(8'd1, 40'd4096, 40'd0, 63'd100);        // forward, over the limit again

    // Random phases, each under its own setting.
    bursty = 1'b1;
    random_phase(400, 8'd1);
    write_reg(gve_pkg::CFG_SEL_RX, 23'd0);
    write_reg(gve_pkg::CFG_SPEED_LIMIT, 23'h7F_FFFF);
    random_phase(400, 8'd0);
    write_reg(gve_pkg::CFG_SEL_RX, 23'd255);
    write_reg(gve_pkg::CFG_SPEED_LIMIT, 23'($urandom_range(1000, 200000)));
    bursty = 1'b0;
    random_phase(400, 8'd255);
    bursty = 1'b1;
    write_reg(gve_pkg::CFG_SEL_RX, 23'd1);
    write_reg(gve_pkg::CFG_SPEED_LIMIT, 23'($urandom));
    random_phase(400, 8'd1);
    write_reg(gve_pkg::CFG_SEL_RX, 23'd170);
    write_reg(gve_pkg::CFG_SPEED_LIMIT, 23'd50000);
    random_phase(400, 8'd170);
    fix_ch.valid <= 1'b0;

    // Drain, then allow one more worst-case fix time for stray results.
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Ran %0d fixes from the selected receivers over five settings,", fixes_used);
    $display("checked %0d speed and heading results in %0d cycles.", results_seen, cycles);
    if (fail_count == 0) begin
      $display("gps_velocity_heading_estimator_unit_tb passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("gps_velocity_heading_estimator_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/gve_pkg.sv
rtl/core/gve_in_if.sv
rtl/core/gve_out_if.sv
rtl/core/gve_seq.sv
rtl/core/gve_dp.sv
rtl/core/gps_velocity_heading_estimator_unit.sv
sim/gve_velocity_checker.sv
sim/gps_velocity_heading_estimator_unit_tb.sv
